// ----- rtl/core/deq_pkg.sv -----
package deq_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  // command codes carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_DROP_FRONT = 3'd2,
    CMD_DROP_BACK  = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  // status codes carried on the output tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_STORED  = 3'd0,
    STAT_REMOVED = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_LISTED  = 3'd4
  } status_t;

endpackage

// ----- rtl/core/deq_mem.sv -----
module deq_mem
  import deq_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one write port, one registered read port; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/double_ended_queue_core.sv -----
// Push and drop: result valid in the cycle after execution (at accept unless parked).
// List: each element is read through the single registered read port of the element
// memory, then loaded into the output register; one per cycle while the output is taken.
// One item is parked while a result waits; tready is low while parked or listing.
// Reset (rst, synchronous): queue empty, front index zero; the element
// memory is not cleared, so there is no clearing pass after reset.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [31:0] value
  input  logic [7:0]        s_axis_tuser,  // [2:0] command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // [31:0] element
  output logic [7:0]        m_axis_tuser,  // [2:0] status
  output logic              m_axis_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_LIST
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;

  // held command when the output register was busy at accept
  cmd_t              hold_cmd;
  logic [DATA_W-1:0] hold_val;

  // listing walk
  logic [IDX_W-1:0]  list_off;
  logic              issued_all;
  logic              rd_pend;
  logic              pend_last;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_element;
  logic              out_last;

  logic              in_acc;
  logic              out_free;
  cmd_t              cur_cmd;
  logic [DATA_W-1:0] cur_val;
  logic              exec_go;
  logic              is_full;
  logic              no_entries;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  logic [IDX_W-1:0]  back_slot;
  logic [IDX_W-1:0]  list_slot;
  logic              list_is_last;
  logic              rd_issue;
  logic              rd_pop;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_rdata;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // command source: straight from the port in idle, else the held copy
  assign cur_cmd = (state == S_IDLE) ? cmd_t'(s_axis_tuser[CMD_W-1:0]) : hold_cmd;
  assign cur_val = (state == S_IDLE) ? s_axis_tdata : hold_val;
  assign exec_go = ((state == S_IDLE && in_acc) || state == S_HOLD) && out_free;

  assign is_full    = (count == CNT_FULL);
  assign no_entries = (count == '0);
  assign front_dec = (front == '0) ? IDX_MAX : front - IDX_W'(1);
  assign front_inc = (front == IDX_MAX) ? '0 : front + IDX_W'(1);
  assign back_slot = wrap_add(front, count[IDX_W-1:0]);
  assign list_slot = wrap_add(front, list_off);
  assign list_is_last = ((CNT_W'(list_off) + CNT_W'(1)) == count);

  // memory writes on a push that fits
  assign mem_we    = exec_go && !is_full &&
                     (cur_cmd == CMD_PUSH_FRONT || cur_cmd == CMD_PUSH_BACK);
  assign mem_waddr = (cur_cmd == CMD_PUSH_FRONT) ? front_dec : back_slot;

  // listing reads: issue when the pending element leaves this cycle or none waits
  assign rd_pop   = (state == S_LIST) && rd_pend && out_free;
  assign rd_issue = (state == S_LIST) && !issued_all && (!rd_pend || out_free);

  deq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cur_val),
    .re    (rd_issue),
    .raddr (list_slot),
    .rdata (mem_rdata)
  );

  // control, queue indices and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      issued_all <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= 1'b0;
      end

      // park the item until the output register frees up
      if (state == S_IDLE && in_acc && !out_free) begin
        hold_cmd <= cmd_t'(s_axis_tuser[CMD_W-1:0]);
        hold_val <= s_axis_tdata;
        state    <= S_HOLD;
      end

      if (exec_go) begin
        state <= S_IDLE;
        case (cur_cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            out_valid   <= 1'b1;
            out_element <= '0;
            out_last    <= 1'b1;
            if (is_full) begin
              out_status <= STAT_FULL;
            end else begin
              out_status <= STAT_STORED;
              count      <= count + CNT_W'(1);
              if (cur_cmd == CMD_PUSH_FRONT) begin
                front <= front_dec;
              end
            end
          end
          CMD_DROP_FRONT, CMD_DROP_BACK: begin
            out_valid   <= 1'b1;
            out_element <= '0;
            out_last    <= 1'b1;
            if (no_entries) begin
              out_status <= STAT_EMPTY;
            end else begin
              out_status <= STAT_REMOVED;
              count      <= count - CNT_W'(1);
              if (cur_cmd == CMD_DROP_FRONT) begin
                front <= front_inc;
              end
            end
          end
          CMD_LIST: begin
            if (no_entries) begin
              out_valid   <= 1'b1;
              out_status  <= STAT_EMPTY;
              out_element <= '0;
              out_last    <= 1'b1;
            end else begin
              state      <= S_LIST;
              list_off   <= '0;
              issued_all <= 1'b0;
              rd_pend    <= 1'b0;
            end
          end
          default: begin
            // unused codes: consumed, no result
          end
        endcase
      end

      // listing walk
      if (rd_issue) begin
        list_off  <= list_off + IDX_W'(1);
        pend_last <= list_is_last;
        rd_pend   <= 1'b1;
        if (list_is_last) begin
          issued_all <= 1'b1;
        end
      end else if (rd_pop) begin
        rd_pend <= 1'b0;
      end

      if (rd_pop) begin
        out_valid   <= 1'b1;
        out_status  <= STAT_LISTED;
        out_element <= mem_rdata;
        out_last    <= pend_last;
        if (pend_last) begin
          state <= S_IDLE;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_element;
  assign m_axis_tuser  = {{(8-STAT_W){1'b0}}, out_status};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("element count above depth");

  a_front_range: assert property (@(posedge clk) disable iff (rst)
    front <= IDX_MAX)
    else $error("front index out of range");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (count != '0))
    else $error("listing an empty queue");

  a_pend_in_list: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_LIST))
    else $error("read data pending outside a listing");

  a_list_done: assert property (@(posedge clk) disable iff (rst)
    rd_pop && pend_last |=> (state == S_IDLE) && m_axis_tvalid && m_axis_tlast)
    else $error("listing did not close on its last element");
`endif

endmodule

// ----- sim/double_ended_queue_core_tb.sv -----
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 70;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t status;
    logic [DATA_W-1:0] element;
    logic last;
  } deq_result_t;

  // Tracks the deque contents and the results each command should produce
  class deque_tracker;
    logic [DATA_W-1:0] slots[DEPTH];
    int unsigned front_idx;
    int unsigned count;
    deq_result_t pending_results[$];
    int errors;
    int commands;
    int ignored;
    int results_checked;
    int lists;
    int full_refusals;
    int empty_answers;

    task report(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH: %s", msg);
    endtask

    function void queue_result(status_t st, logic [DATA_W-1:0] elem, logic fin);
      deq_result_t r;
      r.status = st;
      r.element = elem;
      r.last = fin;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // accepted command: update the deque and queue what it should answer
    function void note_command(logic [CMD_W-1:0] code, logic [DATA_W-1:0] value);
      int unsigned i;
      commands++;
      case (code)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (count == DEPTH) begin
            full_refusals++;
            queue_result(STAT_FULL, '0, 1'b1);
          end else begin
            if (code == CMD_PUSH_FRONT) begin
              front_idx = (front_idx + DEPTH - 1) % DEPTH;
              slots[front_idx] = value;
            end else begin
              slots[(front_idx + count) % DEPTH] = value;
            end
            count++;
            queue_result(STAT_STORED, '0, 1'b1);
          end
        end
        CMD_DROP_FRONT, CMD_DROP_BACK: begin
          if (count == 0) begin
            empty_answers++;
            queue_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            if (code == CMD_DROP_FRONT) front_idx = (front_idx + 1) % DEPTH;
            count--;
            queue_result(STAT_REMOVED, '0, 1'b1);
          end
        end
        CMD_LIST: begin
          lists++;
          if (count == 0) begin
            empty_answers++;
            queue_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < count; i++)
              queue_result(STAT_LISTED, slots[(front_idx + i) % DEPTH], i + 1 == count);
          end
        end
        default: ignored++;
      endcase
    endfunction

    // accepted result: compare against the oldest outstanding one
    task check_result(logic [7:0] user, logic [DATA_W-1:0] data, logic tlast);
      deq_result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d element %h last %b",
                         user[STAT_W-1:0], data, tlast));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (user[STAT_W-1:0] !== want.status)
          report($sformatf("result %0d: status %0d, wanted %0d",
                           results_checked, user[STAT_W-1:0], want.status));
        if (data !== want.element)
          report($sformatf("result %0d: element %h, wanted %h",
                           results_checked, data, want.element));
        if (tlast !== want.last)
          report($sformatf("result %0d: last %b, wanted %b",
                           results_checked, tlast, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [7:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [7:0] m_axis_tuser;
  logic m_axis_tlast;

  deque_tracker tracker = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  bit filling = 1'b1;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side backpressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending_results.size());
      $display("FAIL double_ended_queue_core");
      $finish;
    end
  end

  // drive one command; called and returns at a falling edge
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = $urandom;
      s_axis_tuser = {5'b0, 3'($urandom_range(7))};
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = value;
    s_axis_tuser = {5'b0, code};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_command(code, value);
    @(negedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
  endtask

  // random commands, biased to sweep the deque between empty and full
  task automatic run_phase(input int sidle, input int rstall, input int n_items);
    int made;
    int r;
    logic [CMD_W-1:0] code;
    logic [DATA_W-1:0] v;
    made = 0;
    sender_idle_pct = sidle;
    receiver_stall_pct = rstall;
    while (made < n_items) begin
      if (tracker.count == DEPTH) filling = 1'b0;
      if (tracker.count == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 5) begin
        code = CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
      end else begin
        made++;
        if (r < 18) code = CMD_LIST;
        else if ($urandom_range(99) < (filling ? 70 : 30))
          code = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else
          code = $urandom_range(1) ? CMD_DROP_BACK : CMD_DROP_FRONT;
      end
      case ($urandom_range(9))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = '0;
        3: v = '1;
        default: v = $urandom;
      endcase
      send_command(code, v);
    end
    drain();
  endtask

  initial begin
    int k;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty answers and ignored codes
    send_command(CMD_LIST, 32'h1234_5678);
    send_command(CMD_DROP_FRONT, '0);
    send_command(CMD_DROP_BACK, '1);
    for (k = CMD_SPARE_5; k <= CMD_SPARE_7; k++) send_command(k[CMD_W-1:0], $urandom);
    // fill from both ends, extremes first
    send_command(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    for (k = 0; k < DEPTH - 2; k++)
      send_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                   k[1] ? ~(32'h1 << (2 * k)) : (32'h1 << (2 * k + 1)));
    // refused pushes, full listing, drops from both ends
    send_command(CMD_PUSH_FRONT, 32'hdead_beef);
    send_command(CMD_PUSH_BACK, '0);
    send_command(CMD_LIST, '0);
    send_command(CMD_DROP_FRONT, '0);
    send_command(CMD_DROP_BACK, '0);
    send_command(CMD_LIST, '0);
    drain();

    run_phase(0, 0, ITEMS_PER_PHASE);
    run_phase(84, 0, ITEMS_PER_PHASE);
    run_phase(0, 84, ITEMS_PER_PHASE);
    run_phase(30, 30, ITEMS_PER_PHASE + 2);

    // let any late or spurious result show up
    receiver_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("Ran %0d commands (%0d with spare codes) and checked %0d results",
             tracker.commands, tracker.ignored, tracker.results_checked);
    $display("Listings %0d, full refusals %0d, empty answers %0d, mismatches %0d",
             tracker.lists, tracker.full_refusals, tracker.empty_answers, tracker.errors);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS double_ended_queue_core");
    end else begin
      $display("FAIL double_ended_queue_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/deq_pkg.sv
rtl/core/deq_mem.sv
rtl/core/double_ended_queue_core.sv
sim/double_ended_queue_core_tb.sv
